// ===== src/qms_pkg.sv =====
// Shared types and constants for the query match scorer.
// Holds query geometry, stream word types, register indexes and class codes.
// No dependencies; every other file in the block imports this package.
package qms_pkg;

  localparam int QUERY_MAX      = 32;
  localparam int QIDX_W         = $clog2(QUERY_MAX);
  localparam int LEN_W          = $clog2(QUERY_MAX + 1);
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int BYTES_PER_WORD = CFG_DATA_W / 8;
  localparam int NUM_WORDS      = QUERY_MAX / BYTES_PER_WORD;
  localparam int IN_TDATA_W     = 16;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 8;
  localparam int CLASS_W        = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_D      = 3'd4;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    KIND_TITLE  = 2'd0,
    KIND_ID     = 2'd1,
    KIND_BLOB   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_PREFIX      = 3'd0,
    CLS_TITLE       = 3'd1,
    CLS_ID          = 3'd2,
    CLS_BLOB        = 3'd3,
    CLS_SUBSEQUENCE = 3'd4,
    CLS_NONE        = 3'd5
  } match_class_t;

  // One byte of a candidate string as it enters the scorer.
  typedef struct packed {
    kind_t kind;
    byte_t char_byte;
    logic  has_char;
    logic  end_of_string;
  } item_t;

  // Query as seen by the scoring logic: saturated length and the bytes.
  typedef struct packed {
    logic [LEN_W-1:0]                eff_len;
    logic [QUERY_MAX-1:0][7:0]       qbytes;
  } query_t;

endpackage

// ===== src/qms_cfg_regs.sv =====
// Query configuration registers of the query match scorer.
// Depends on qms_pkg; presents the saturated length and query bytes to the core.
module qms_cfg_regs
  import qms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output query_t                query
);

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] words_r [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        words_r[w] <= '0;
      end
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_QUERY_LENGTH: len_r      <= cfg_wdata[LEN_W-1:0];
        CFG_QUERY_A:      words_r[0] <= cfg_wdata;
        CFG_QUERY_B:      words_r[1] <= cfg_wdata;
        CFG_QUERY_C:      words_r[2] <= cfg_wdata;
        CFG_QUERY_D:      words_r[3] <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Lengths beyond the query storage saturate to the full query.
  always_comb begin
    query.eff_len = (len_r > LEN_W'(QUERY_MAX)) ? LEN_W'(QUERY_MAX) : len_r;
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
        query.qbytes[w*BYTES_PER_WORD + b] = words_r[w][b*8 +: 8];
      end
    end
  end

endmodule

// ===== src/qms_core.sv =====
// Candidate scoring state of the query match scorer: shift-and vector,
// title prefix check, hit flags and blob subsequence pointer. Depends on qms_pkg.
module qms_core
  import qms_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  item_t        item,
  input  query_t       query,
  output logic         emit,
  output match_class_t match_class
);

  logic [QUERY_MAX-1:0] mv_r, mv_nxt;
  logic [LEN_W-1:0]     pc_r, pc_nxt;
  logic                 broken_r, broken_nxt;
  logic [2:0]           hit_r, hit_nxt;
  logic [LEN_W-1:0]     sc_r, sc_nxt;

  logic [QUERY_MAX-1:0] byte_match;
  logic [QUERY_MAX-1:0] mv_shift;
  logic [QIDX_W-1:0]    top_idx;
  logic                 active;
  logic                 len_nz;

  always_comb begin
    for (int i = 0; i < QUERY_MAX; i++) begin
      byte_match[i] = (query.qbytes[i] == item.char_byte) &&
                      (LEN_W'(i) < query.eff_len);
    end

    active   = step && (item.kind != KIND_UNUSED);
    len_nz   = (query.eff_len != '0);
    mv_shift = {mv_r[QUERY_MAX-2:0], 1'b1} & byte_match;
    top_idx  = QIDX_W'(query.eff_len - LEN_W'(1));

    mv_nxt     = mv_r;
    pc_nxt     = pc_r;
    broken_nxt = broken_r;
    hit_nxt    = hit_r;
    sc_nxt     = sc_r;

    if (active && item.has_char && len_nz) begin
      mv_nxt = mv_shift;
      if (mv_shift[top_idx]) begin
        hit_nxt[2'(item.kind)] = 1'b1;
      end
      if (item.kind == KIND_TITLE && !broken_r && pc_r < query.eff_len) begin
        if (query.qbytes[pc_r[QIDX_W-1:0]] == item.char_byte) begin
          pc_nxt = pc_r + LEN_W'(1);
        end else begin
          broken_nxt = 1'b1;
        end
      end
      if (item.kind == KIND_BLOB && sc_r < query.eff_len &&
          query.qbytes[sc_r[QIDX_W-1:0]] == item.char_byte) begin
        sc_nxt = sc_r + LEN_W'(1);
      end
    end

    if (active && item.end_of_string) begin
      mv_nxt = '0;
    end

    emit = active && item.end_of_string && (item.kind == KIND_BLOB);

    priority if (!len_nz || (!broken_nxt && pc_nxt == query.eff_len)) begin
      match_class = CLS_PREFIX;
    end else if (hit_nxt[0]) begin
      match_class = CLS_TITLE;
    end else if (hit_nxt[1]) begin
      match_class = CLS_ID;
    end else if (hit_nxt[2]) begin
      match_class = CLS_BLOB;
    end else if (sc_nxt == query.eff_len) begin
      match_class = CLS_SUBSEQUENCE;
    end else begin
      match_class = CLS_NONE;
    end

    // The blob's last word closes the candidate.
    if (emit) begin
      pc_nxt     = '0;
      broken_nxt = 1'b0;
      hit_nxt    = '0;
      sc_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r     <= '0;
      pc_r     <= '0;
      broken_r <= 1'b0;
      hit_r    <= '0;
      sc_r     <= '0;
    end else begin
      mv_r     <= mv_nxt;
      pc_r     <= pc_nxt;
      broken_r <= broken_nxt;
      hit_r    <= hit_nxt;
      sc_r     <= sc_nxt;
    end
  end

  a_empty_query_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && query.eff_len == '0) |-> (match_class == CLS_PREFIX))
    else $error("empty query did not score as prefix");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (hit_r == '0 && sc_r == '0 && pc_r == '0 && !broken_r && mv_r == '0))
    else $error("candidate state not cleared after result");

  a_kind_unused_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.kind == KIND_UNUSED) |=> ($stable(hit_r) && $stable(mv_r) &&
                                             $stable(sc_r) && $stable(pc_r)))
    else $error("unused kind changed candidate state");

endmodule

// ===== src/query_match_scorer.sv =====
// Top level of the query match scorer: stream ports, input register, result register.
// Depends on qms_pkg, qms_cfg_regs and qms_core.
//
// Usage: the query is loaded through the cfg_ write port (index 0 length,
// indexes 1 to 4 the query bytes, eight to a register) while the block is idle.
// A candidate then streams in on the in_ channel, one byte per word: tuser
// selects title, id or keyword blob, tdata carries the byte and its valid flag,
// and tlast marks the last word of each string. Words of the unused kind are
// dropped. After the blob's last word one result word leaves on the out_
// channel carrying the match class, and the candidate state clears.
// Throughput is one word per cycle unless a result waits behind a held one:
// a word is captured in the input register, then the scoring state and the
// result register update from it, so out_tvalid is registered. The shift-and
// vector and counters update once per word, which sets that rate.
// When the receiver stalls, the result register holds; words that produce no
// result keep flowing, and only a second result waiting behind a held one
// stops in_tready. Reset (synchronous, active low) clears the query registers
// and all candidate state; the block takes words in the cycle after reset.
module query_match_scorer
  import qms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_byte, [8] has_char, rest zero
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] kind
  input  logic                   in_tlast,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] match_class, rest zero
);

  query_t       query;
  item_t        s1_item_r;
  logic         s1_valid_r;
  logic         out_valid_r;
  match_class_t out_class_r;

  logic         produce;
  logic         out_free;
  logic         s1_adv;
  logic         in_fire;
  logic         emit;
  match_class_t core_class;

  qms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .query     (query)
  );

  qms_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .item        (s1_item_r),
    .query       (query),
    .emit        (emit),
    .match_class (core_class)
  );

  // The registered word moves on unless it closes a candidate and the
  // result register is still occupied by an untaken result.
  assign produce   = s1_valid_r && s1_item_r.end_of_string && (s1_item_r.kind == KIND_BLOB);
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!produce || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind          <= kind_t'(in_tuser);
      s1_item_r.char_byte     <= in_tdata[7:0];
      s1_item_r.has_char      <= in_tdata[8];
      s1_item_r.end_of_string <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_class_r <= core_class;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CLASS_W){1'b0}}, out_class_r};

  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && out_valid_r && !out_tready) |-> (!in_tready && !emit))
    else $error("result would overwrite an untaken result");

  a_emit_only_on_blob_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (s1_adv && produce))
    else $error("result raised without a closing blob word");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result register not loaded");

endmodule

// ===== dv/qms_checker.sv =====
// Scoreboard for the query match scorer: mirrors the query registers and the
// candidate state from the observed words and checks every result word.
// Depends on qms_pkg; instantiated beside the block by query_match_scorer_test.
module qms_checker
  import qms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_byte, [8] has_char, rest zero
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] kind
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] match_class, rest zero
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEN_W-1:0]      query_len_q;
  logic [CFG_DATA_W-1:0] query_word_q [NUM_WORDS];
  logic [QUERY_MAX-1:0]  match_vec;
  logic [LEN_W-1:0]      prefix_cnt;
  logic                  prefix_broken;
  logic [2:0]            hit_flags;
  logic [LEN_W-1:0]      subseq_cnt;
  match_class_t          expected_classes [$];

  function automatic int unsigned active_len();
    return (query_len_q > QUERY_MAX) ? QUERY_MAX : query_len_q;
  endfunction

  function automatic byte_t query_byte_at(int unsigned pos);
    if (pos >= QUERY_MAX) return 8'h00;
    return query_word_q[pos / BYTES_PER_WORD][(pos % BYTES_PER_WORD) * 8 +: 8];
  endfunction

  task automatic clear_candidate();
    match_vec     = '0;
    prefix_cnt    = '0;
    prefix_broken = 1'b0;
    hit_flags     = '0;
    subseq_cnt    = '0;
  endtask

  // Advances the candidate state by one word and queues a class when the
  // word closes the keyword blob.
  task automatic score_word(input kind_t kind, input byte_t c, input logic has,
                            input logic last);
    int unsigned          n;
    logic [QUERY_MAX-1:0] hits_here;
    match_class_t         cls;
    n = active_len();
    if (kind == KIND_UNUSED) return;
    if (has && n > 0) begin
      hits_here = '0;
      for (int i = 0; i < n; i++)
        if (query_byte_at(i) == c) hits_here[i] = 1'b1;
      match_vec = ((match_vec << 1) | 1) & hits_here;
      if (match_vec[n-1]) hit_flags[kind] = 1'b1;
      if (kind == KIND_TITLE && !prefix_broken && prefix_cnt < n) begin
        if (query_byte_at(prefix_cnt) == c) prefix_cnt++;
        else prefix_broken = 1'b1;
      end
      if (kind == KIND_BLOB && subseq_cnt < n && query_byte_at(subseq_cnt) == c)
        subseq_cnt++;
    end
    if (!last) return;
    match_vec = '0;
    if (kind != KIND_BLOB) return;
    if (n == 0 || (!prefix_broken && prefix_cnt == n)) cls = CLS_PREFIX;
    else if (hit_flags[KIND_TITLE])                     cls = CLS_TITLE;
    else if (hit_flags[KIND_ID])                        cls = CLS_ID;
    else if (hit_flags[KIND_BLOB])                      cls = CLS_BLOB;
    else if (subseq_cnt == n)                           cls = CLS_SUBSEQUENCE;
    else                                                cls = CLS_NONE;
    expected_classes = {expected_classes, cls};
    clear_candidate();
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    match_class_t want;
    if (!rst_n) begin
      query_len_q = '0;
      for (int w = 0; w < NUM_WORDS; w++) query_word_q[w] = '0;
      clear_candidate();
      expected_classes.delete();
    end else begin
      // Results leave only after their blob word has passed the input and result
      // registers, so the output side is handled first; the order does not change what is queued.
      if (out_tvalid && out_tready) begin
        if (expected_classes.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word 0x%02h arrived with none expected", $realtime,
                     out_tdata);
          fail_count++;
        end else begin
          want = expected_classes.pop_front();
          if (out_tdata !== OUT_TDATA_W'(want)) begin
            if (fail_count < 10)
              $display("%0t: match_class expected %0d (%s), got word 0x%02h", $realtime,
                       want, want.name(), out_tdata);
            fail_count++;
          end
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          CFG_QUERY_LENGTH: query_len_q     = cfg_wdata[LEN_W-1:0];
          CFG_QUERY_A:      query_word_q[0] = cfg_wdata;
          CFG_QUERY_B:      query_word_q[1] = cfg_wdata;
          CFG_QUERY_C:      query_word_q[2] = cfg_wdata;
          CFG_QUERY_D:      query_word_q[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        score_word(kind_t'(in_tuser), in_tdata[7:0], in_tdata[8], in_tlast);
    end
    pending = expected_classes.size();
  end

endmodule

// ===== dv/query_match_scorer_test.sv =====
// Top of the query match scorer testbench: clock, reset, query loading and
// candidate stimulus with random idling on both streams, plus the verdict.
// Depends on qms_pkg, the block query_match_scorer and the qms_checker scoreboard.
module query_match_scorer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qms_pkg::*;

  typedef byte_t bytes_q_t [$];

  // Roughly how many random words (unused-kind words not counted) to send.
  localparam int RANDOM_ITEMS = 1000;
  // Words per phase before the query is changed again.
  localparam int PHASE_ITEMS  = 60;
  // The last stretch of the run keeps both streams busy with no idling.
  localparam int QUIET_TAIL   = 150;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] char_byte, [8] has_char, rest zero
  logic [IN_TUSER_W-1:0]  in_tuser;   // [1:0] kind
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [2:0] match_class, rest zero

  int fail_count;
  int pending_results;

  // Stimulus-side view of the current query; the checker keeps its own copy
  // from the register writes it observes.
  byte_t       qbytes [QUERY_MAX];
  int unsigned qlen;
  int unsigned items_sent = 0;
  int unsigned tx_gap_pct = 20;
  int unsigned rx_stall_pct = 20;

  query_match_scorer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  qms_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // This timeout leaves a wide margin over the worst honest run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result receiver: random stall bursts, otherwise ready.
  // Inputs change only on the falling edge, so the block samples stable values.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Presents one word and holds it until the block takes it. The task is
  // entered and left on a falling edge; in_tvalid stays high between back to
  // back words so it never gets two assignments in one step.
  task automatic send_word(input kind_t kind, input byte_t c, input logic has,
                           input logic last);
    if (kind != KIND_UNUSED) items_sent++;
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {7'd0, has, c};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends one string. An empty string becomes a single byte-less word with
  // tlast set. Inside a string, byte-less words and unused-kind words are
  // sprinkled in now and then; neither may disturb the matching.
  task automatic send_string(input kind_t kind, input bytes_q_t s);
    if (s.size() == 0) begin
      send_word(kind, byte_t'($urandom), 1'b0, 1'b1);
      return;
    end
    foreach (s[i]) begin
      if ($urandom_range(0, 19) == 0)
        send_word(kind, byte_t'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 29) == 0)
        send_word(KIND_UNUSED, byte_t'($urandom), 1'($urandom), 1'($urandom));
      send_word(kind, s[i], 1'b1, i == s.size() - 1);
    end
  endtask

  // A small alphabet keeps accidental partial matches frequent.
  function automatic byte_t filler_byte();
    return byte_t'(8'h61 + $urandom_range(0, 3));
  endfunction

  // Builds a string aimed at one kind of hit against the current query:
  // none, plain filler, a prefix, an embedded copy, a scattered copy, a copy
  // with one byte wrong, or arbitrary bytes.
  function automatic bytes_q_t make_text(input int unsigned mode);
    bytes_q_t    s;
    int unsigned n;
    int unsigned bad;
    n = (qlen > QUERY_MAX) ? QUERY_MAX : qlen;
    if (n == 0 && mode >= 2 && mode <= 5) mode = 1;
    case (mode)
      0: ;
      1: repeat ($urandom_range(1, 8)) s = {s, filler_byte()};
      2: begin
        for (int i = 0; i < n; i++) s = {s, qbytes[i]};
        repeat ($urandom_range(0, 3)) s = {s, filler_byte()};
      end
      3: begin
        repeat ($urandom_range(1, 4)) s = {s, filler_byte()};
        for (int i = 0; i < n; i++) s = {s, qbytes[i]};
        repeat ($urandom_range(0, 3)) s = {s, filler_byte()};
      end
      4: begin
        for (int i = 0; i < n; i++) begin
          s = {s, qbytes[i]};
          repeat ($urandom_range(0, 2)) s = {s, filler_byte()};
        end
      end
      5: begin
        bad = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
          s = {s, (i == bad) ? byte_t'(qbytes[i] ^ 8'h01) : qbytes[i]};
      end
      default: repeat ($urandom_range(1, 8)) s = {s, byte_t'($urandom)};
    endcase
    return s;
  endfunction

  // Writes all five query registers on consecutive cycles. The block must be
  // idle when this is called.
  task automatic load_query();
    logic [CFG_DATA_W-1:0] word;
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_QUERY_LENGTH;
    cfg_wdata <= CFG_DATA_W'(qlen);
    @(negedge clk);
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int b = 0; b < BYTES_PER_WORD; b++)
        word[b*8 +: 8] = qbytes[w*BYTES_PER_WORD + b];
      cfg_index <= CFG_IDX_W'(CFG_QUERY_A + w);
      cfg_wdata <= word;
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  // Stops the input stream, waits until every predicted class has come out,
  // then lets the pipeline settle so no word is still in flight.
  task automatic drain(input int unsigned settle);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Picks a new query. Short lengths dominate; the empty query, the full 32
  // bytes and lengths beyond the limit (which saturate) show up regularly.
  task automatic new_query();
    int unsigned pick;
    logic        full_range;
    pick = $urandom_range(0, 19);
    if (pick == 0)      qlen = 0;
    else if (pick == 1) qlen = QUERY_MAX;
    else if (pick == 2) qlen = $urandom_range(QUERY_MAX + 1, 63);
    else if (pick < 5)  qlen = $urandom_range(7, QUERY_MAX - 1);
    else                qlen = $urandom_range(1, 6);
    full_range = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < QUERY_MAX; i++)
      qbytes[i] = full_range ? byte_t'($urandom) : filler_byte();
  endtask

  // Most candidates are well formed: titles, an id, then the blob that closes
  // them. A tenth are strings of random kinds in random order.
  task automatic send_candidate();
    int unsigned titles;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        send_string(kind_t'($urandom_range(0, 2)), make_text($urandom_range(0, 6)));
      return;
    end
    titles = $urandom_range(0, 9);
    titles = (titles == 0) ? 0 : (titles == 1) ? 2 : 1;
    repeat (titles) send_string(KIND_TITLE, make_text($urandom_range(0, 6)));
    if ($urandom_range(0, 6) != 0)
      send_string(KIND_ID, make_text($urandom_range(0, 6)));
    send_string(KIND_BLOB, make_text($urandom_range(0, 6)));
  endtask

  initial begin
    bytes_q_t    nil;
    bytes_q_t    s;
    int unsigned random_start;
    int unsigned phase_start;

    rst_n     <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_index <= CFG_QUERY_LENGTH;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_TITLE;
    in_tlast  <= 1'b0;
    qlen = 0;
    for (int i = 0; i < QUERY_MAX; i++) qbytes[i] = 8'h00;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The query is empty after reset, so any candidate scores
    // as a prefix match, even one whose blob is only a byte-less word.
    send_string(KIND_BLOB, nil);
    s = '{8'h7a};
    send_string(KIND_TITLE, s);
    send_string(KIND_BLOB, nil);

    // Query "ab": walk through every class.
    drain(4);
    qlen = 2;
    for (int i = 0; i < QUERY_MAX; i++) qbytes[i] = byte_t'($urandom);
    qbytes[0] = 8'h61;
    qbytes[1] = 8'h62;
    load_query();
    s = '{8'h61, 8'h62};
    send_string(KIND_TITLE, s);
    send_string(KIND_BLOB, nil);
    // Two titles: the prefix check runs across both of them.
    s = '{8'h61};
    send_string(KIND_TITLE, s);
    s = '{8'h62};
    send_string(KIND_TITLE, s);
    send_string(KIND_BLOB, nil);
    s = '{8'h63, 8'h61, 8'h62};
    send_string(KIND_TITLE, s);
    send_string(KIND_BLOB, nil);
    s = '{8'h61, 8'h62};
    send_string(KIND_ID, s);
    send_string(KIND_BLOB, nil);
    s = '{8'h00, 8'h61, 8'h62};
    send_string(KIND_BLOB, s);
    s = '{8'h61, 8'hff, 8'h62};
    send_string(KIND_BLOB, s);
    // An unused-kind word that claims to close the blob must be dropped.
    send_word(KIND_UNUSED, 8'hff, 1'b1, 1'b1);
    s = '{8'hff};
    send_string(KIND_BLOB, s);

    // A length beyond the limit saturates to the full query.
    drain(4);
    qlen = 63;
    for (int i = 0; i < QUERY_MAX; i++) qbytes[i] = byte_t'($urandom);
    load_query();
    send_string(KIND_BLOB, make_text(3));

    // Random part, in phases that each use a new query and new idling rates.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain(4);
      new_query();
      load_query();
      if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 5;
          default: tx_gap_pct = 25;
        endcase
        case ($urandom_range(0, 3))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 5;
          default: rx_stall_pct = 25;
        endcase
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_candidate();
      // Close any half-finished candidate so each phase ends with a result.
      send_string(KIND_BLOB, make_text($urandom_range(0, 6)));
    end

    drain(8);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
